[hdl/dgs_pkg.sv]
// Shared constants, register indexes and types of the ducking gain smoother.
package dgs_pkg;

    // Default sample width of the microphone channels.
    localparam int DGS_SAMPLE_WIDTH = 16;

    // Index and data widths of the configuration port.
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 16;

    // Gain and level constants, Q1.15 and plain magnitude.
    localparam logic [15:0] UNITY_GAIN = 16'd32768;
    localparam logic [15:0] DUCK_LIMIT = 16'd32440;
    localparam logic [15:0] PEAK_MAX   = 16'hFFFF;

    // Reset values of the configuration registers.
    localparam logic [14:0] THRESHOLD_RESET = 15'd3277;
    localparam logic [15:0] DEPTH_RESET     = 16'd8192;
    localparam logic [15:0] ATTACK_RESET    = 16'd6554;
    localparam logic [15:0] RELEASE_RESET   = 16'd655;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_THRESHOLD = 3'd0,
        CFG_DEPTH     = 3'd1,
        CFG_ATTACK    = 3'd2,
        CFG_RELEASE   = 3'd3,
        CFG_MONO      = 3'd4
    } cfg_index_t;

    // Current register settings.
    typedef struct packed {
        logic [14:0] threshold;
        logic [15:0] depth;
        logic [15:0] attack_coeff;
        logic [15:0] release_coeff;
        logic        mono_mic;
    } cfg_t;

    // One result item.
    typedef struct packed {
        logic [15:0] smooth_gain;
        logic        ducking_on;
        logic [15:0] block_peak;
        logic        peak_ready;
    } res_t;

endpackage

[hdl/dgs_in_if.sv]
// Stream interface that carries microphone frames.
interface dgs_in_if
    import dgs_pkg::*;
#(
    parameter int SAMPLE_WIDTH = DGS_SAMPLE_WIDTH
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] mic_left;
    logic signed [SAMPLE_WIDTH-1:0] mic_right;
    logic                           block_end;

    modport source (output valid, output mic_left, output mic_right, output block_end,
                    input ready);
    modport sink (input valid, input mic_left, input mic_right, input block_end,
                  output ready);
endinterface

[hdl/dgs_out_if.sv]
// Stream interface that carries gain results.
interface dgs_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] smooth_gain;
    logic        ducking_on;
    logic [15:0] block_peak;
    logic        peak_ready;

    modport source (output valid, output smooth_gain, output ducking_on, output block_peak,
                    output peak_ready, input ready);
    modport sink (input valid, input smooth_gain, input ducking_on, input block_peak,
                  input peak_ready, output ready);
endinterface

[hdl/dgs_cfg_regs.sv]
// Configuration register file of the ducking gain smoother.
module dgs_cfg_regs
    import dgs_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_wdata,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write; unused indexes leave the registers alone.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_THRESHOLD: cfg_next.threshold     = cfg_wdata[14:0];
                CFG_DEPTH:     cfg_next.depth         = cfg_wdata;
                CFG_ATTACK:    cfg_next.attack_coeff  = cfg_wdata;
                CFG_RELEASE:   cfg_next.release_coeff = cfg_wdata;
                CFG_MONO:      cfg_next.mono_mic      = cfg_wdata[0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    // Register storage with reset defaults.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold     <= THRESHOLD_RESET;
            cfg_reg.depth         <= DEPTH_RESET;
            cfg_reg.attack_coeff  <= ATTACK_RESET;
            cfg_reg.release_coeff <= RELEASE_RESET;
            cfg_reg.mono_mic      <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

    // Writes to an unused index change nothing.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_wr_en && cfg_index > CFG_MONO) |=> $stable(cfg_reg))
        else $error("configuration changed on a write to an unused index");

    // Without a write the settings hold.
    assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_wr_en |=> $stable(cfg_reg))
        else $error("configuration changed without a write");

    // A threshold write lands in the threshold register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_wr_en && cfg_index == CFG_THRESHOLD) |=> cfg_reg.threshold == $past(cfg_wdata[14:0]))
        else $error("threshold write lost");

endmodule

[hdl/dgs_core.sv]
// Peak tracker and one-pole gain smoother with their state registers.
module dgs_core
    import dgs_pkg::*;
#(
    parameter int SAMPLE_WIDTH = DGS_SAMPLE_WIDTH
)(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           advance,
    input  logic signed [SAMPLE_WIDTH-1:0] mic_left,
    input  logic signed [SAMPLE_WIDTH-1:0] mic_right,
    input  logic                           block_end,
    input  cfg_t                           cfg,
    output res_t                           res
);

    localparam int MAG_WIDTH = (SAMPLE_WIDTH > 16) ? SAMPLE_WIDTH : 16;

    logic [15:0]        peak_reg, peak_next;
    logic [15:0]        gain_reg, gain_next;
    logic               duck_reg, duck_next;

    logic [15:0]        mag_left, mag_right, mag_r_sel;
    logic [15:0]        peak_lft, peak_all;
    logic [14:0]        thr_eff;
    logic [15:0]        dep_eff;
    logic [15:0]        target;
    logic [15:0]        coeff;
    logic signed [16:0] diff;
    logic signed [33:0] prod;
    logic signed [33:0] biased;
    logic signed [17:0] step;
    logic signed [18:0] gain_sum;
    logic [15:0]        gain_upd;

    // Absolute value of a sample, saturated to the 16-bit peak range.
    function automatic logic [15:0] mag_sat(input logic signed [SAMPLE_WIDTH-1:0] s);
        logic [SAMPLE_WIDTH-1:0] m;
        logic [MAG_WIDTH-1:0]    me;
        m  = s[SAMPLE_WIDTH-1] ? (~$unsigned(s) + SAMPLE_WIDTH'(1)) : $unsigned(s);
        me = MAG_WIDTH'(m);
        mag_sat = (me > MAG_WIDTH'(PEAK_MAX)) ? PEAK_MAX : me[15:0];
    endfunction

    // Fold both channels into the running block peak; in mono mode the left channel stands in for the right.
    always_comb
    begin
        mag_left  = mag_sat(mic_left);
        mag_right = mag_sat(mic_right);
        mag_r_sel = cfg.mono_mic ? mag_left : mag_right;
        peak_lft  = (mag_left > peak_reg) ? mag_left : peak_reg;
        peak_all  = (mag_r_sel > peak_lft) ? mag_r_sel : peak_lft;
    end

    // Target gain, smoothing step and clamp for the block end.
    always_comb
    begin
        thr_eff  = (cfg.threshold == 15'd0) ? 15'd1 : cfg.threshold;
        dep_eff  = (cfg.depth > UNITY_GAIN) ? UNITY_GAIN : cfg.depth;
        target   = (peak_all >= {1'b0, thr_eff}) ? dep_eff : UNITY_GAIN;
        coeff    = (target < gain_reg) ? cfg.attack_coeff : cfg.release_coeff;
        diff     = $signed({1'b0, target}) - $signed({1'b0, gain_reg});
        prod     = diff * $signed({1'b0, coeff});
        biased   = prod + 34'sd32768;
        step     = biased[33:16];
        gain_sum = $signed({3'b000, gain_reg}) + $signed({step[17], step});
        if (gain_sum < $signed({3'b000, dep_eff}))
        begin
            gain_upd = dep_eff;
        end
        else if (gain_sum > $signed({3'b000, UNITY_GAIN}))
        begin
            gain_upd = UNITY_GAIN;
        end
        else
        begin
            gain_upd = gain_sum[15:0];
        end
    end

    // On advance, a block end updates gain and duck flag and clears the peak; other frames fold the peak.
    always_comb
    begin
        peak_next = peak_reg;
        gain_next = gain_reg;
        duck_next = duck_reg;
        if (advance)
        begin
            if (block_end)
            begin
                peak_next = 16'd0;
                gain_next = gain_upd;
                duck_next = (target <= DUCK_LIMIT);
            end
            else
            begin
                peak_next = peak_all;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg <= 16'd0;
            gain_reg <= UNITY_GAIN;
            duck_reg <= 1'b0;
        end
        else
        begin
            peak_reg <= peak_next;
            gain_reg <= gain_next;
            duck_reg <= duck_next;
        end
    end

    // Result of the frame that is being processed.
    always_comb
    begin
        res.smooth_gain = block_end ? gain_upd : gain_reg;
        res.ducking_on  = block_end ? (target <= DUCK_LIMIT) : duck_reg;
        res.block_peak  = block_end ? peak_all : 16'd0;
        res.peak_ready  = block_end;
    end

    // A finished block leaves the running peak cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && block_end) |=> peak_reg == 16'd0)
        else $error("running peak not cleared at block end");

    // The smoothed gain never exceeds unity.
    assert property (@(posedge clk) disable iff (!rst_n)
        gain_reg <= UNITY_GAIN)
        else $error("smoothed gain above unity");

    // Gain and duck flag only change on a block end.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(advance && block_end) |=> ($stable(gain_reg) && $stable(duck_reg)))
        else $error("gain state changed outside a block end");

endmodule

[hdl/ducking_gain_smoother.sv]
// Top level of the ducking gain smoother: input register, core and result register.
// A frame taken into the input register passes through the combinational core into the
// result register, which takes it only when empty or when its result is being read.
// Throughput: one frame per cycle absent result stalls; the gain recurrence is combinational.
// Reset: rst_n clears the pipeline valids, sets gain to unity, peak and duck flag to zero and
// loads the register defaults; no clearing pass is needed.
module ducking_gain_smoother
    import dgs_pkg::*;
#(
    parameter int SAMPLE_WIDTH = DGS_SAMPLE_WIDTH
)(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_wdata,
    dgs_in_if.sink                     frame,
    dgs_out_if.source                  result
);

    cfg_t cfg;
    res_t res;

    logic                           s1_valid_reg, s1_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] s1_left_reg;
    logic signed [SAMPLE_WIDTH-1:0] s1_right_reg;
    logic                           s1_end_reg;
    logic                           out_valid_reg, out_valid_next;
    res_t                           out_res_reg;

    logic out_free;
    logic advance;
    logic frame_take;

    dgs_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    dgs_core #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .mic_left  (s1_left_reg),
        .mic_right (s1_right_reg),
        .block_end (s1_end_reg),
        .cfg       (cfg),
        .res       (res)
    );

    // Handshake: the result register frees up when empty or when taken.
    always_comb
    begin
        out_free    = !out_valid_reg || result.ready;
        advance     = s1_valid_reg && out_free;
        frame.ready = !s1_valid_reg || out_free;
        frame_take  = frame.valid && frame.ready;
    end

    // Valid flags of the input and result registers.
    always_comb
    begin
        s1_valid_next  = frame_take ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
        out_valid_next = advance ? 1'b1 : (result.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (frame_take)
        begin
            s1_left_reg  <= frame.mic_left;
            s1_right_reg <= frame.mic_right;
            s1_end_reg   <= frame.block_end;
        end
        if (advance)
        begin
            out_res_reg <= res;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.smooth_gain = out_res_reg.smooth_gain;
    assign result.ducking_on  = out_res_reg.ducking_on;
    assign result.block_peak  = out_res_reg.block_peak;
    assign result.peak_ready  = out_res_reg.peak_ready;

    // An empty input register always takes a frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> frame.ready)
        else $error("input register empty but not ready");

    // The block peak is zero on frames that do not end a block.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_res_reg.peak_ready) |-> out_res_reg.block_peak == 16'd0)
        else $error("block peak set on a frame inside a block");

    // A processed frame always shows up in the result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed frame lost");

    // Reported gain stays within unity.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_res_reg.smooth_gain <= UNITY_GAIN)
        else $error("result gain above unity");

endmodule

[tb/sv/ducking_gain_smoother_tb.sv]
// Self-checking testbench for the ducking gain smoother: directed frames, then random blocks.
`timescale 1ns / 1ps

module ducking_gain_smoother_tb;
    import dgs_pkg::*;

    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 11;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 20;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 150;
    localparam int NUM_DIRECTED   = 16;
    localparam int NUM_PHASES     = 6;

    typedef logic signed [DGS_SAMPLE_WIDTH-1:0] sample_t;

    // One row of the directed frame table; the typed result is used only when fixed is set.
    typedef struct packed {
        sample_t left;
        sample_t right;
        logic    last;
        logic    fixed;
        res_t    want;
    } frame_row_t;

    // Register words and idle rates of one random phase.
    typedef struct {
        logic [CFG_DATA_WIDTH-1:0] thr_word;
        logic [CFG_DATA_WIDTH-1:0] depth_word;
        logic [CFG_DATA_WIDTH-1:0] attack_word;
        logic [CFG_DATA_WIDTH-1:0] release_word;
        logic [CFG_DATA_WIDTH-1:0] mono_word;
        int                        send_idle;
        int                        recv_idle;
    } phase_setup_t;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       cfg_wr_en;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_DATA_WIDTH-1:0]  cfg_wdata;

    dgs_in_if  frame_if ();
    dgs_out_if result_if ();

    ducking_gain_smoother dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .frame     (frame_if),
        .result    (result_if)
    );

    // Register copy and gain state of the predictor.
    cfg_t  reg_model;
    int    peak_track;
    int    gain_track;
    logic  duck_track;

    res_t  gain_expect_q [$];
    int    err_count    = 0;
    int    frames_sent  = 0;
    int    blocks_seen  = 0;
    int    ducked_seen  = 0;
    int    send_idle    = 0;
    int    stall_pct    = 0;
    int    quiet_cycles = 0;

    // Directed frames under the reset register values (threshold 3277, depth 8192).
    frame_row_t directed_rows [NUM_DIRECTED] = '{
        '{16'sd0,      16'sd0,      1'b0, 1'b1, '{UNITY_GAIN, 1'b0, 16'd0,   1'b0}},
        '{16'sd100,    -16'sd200,   1'b1, 1'b1, '{UNITY_GAIN, 1'b0, 16'd200, 1'b1}},
        '{16'sd32767,  16'sd0,      1'b0, 1'b1, '{UNITY_GAIN, 1'b0, 16'd0,   1'b0}},
        '{16'sh8000,   16'sd5,      1'b1, 1'b0, '0},
        '{16'sd0,      16'sd0,      1'b1, 1'b0, '0},
        '{16'sd3277,   16'sd0,      1'b1, 1'b0, '0},
        '{-16'sd3276,  16'sd3276,   1'b1, 1'b0, '0},
        '{16'sh5555,   16'shAAAA,   1'b0, 1'b0, '0},
        '{16'sh2AAA,   16'shD555,   1'b1, 1'b0, '0},
        '{16'sd1,      -16'sd1,     1'b0, 1'b0, '0},
        '{16'sd0,      16'sh8000,   1'b1, 1'b0, '0},
        '{16'sd32767,  -16'sd32767, 1'b1, 1'b0, '0},
        '{16'sd0,      16'sd0,      1'b1, 1'b0, '0},
        '{16'sd10,     16'sd3276,   1'b1, 1'b0, '0},
        '{-16'sd1,     16'sd0,      1'b1, 1'b0, '0},
        '{16'sd0,      16'sd0,      1'b1, 1'b0, '0}
    };

    // Settings of the random phases: extremes first, then mid-range values.
    phase_setup_t phase_setups [NUM_PHASES] = '{
        '{16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 35, 63},
        '{16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 35, 63},
        '{16'd1,    16'd32440, 16'd32768, 16'd1000, 16'd1,  63, 35},
        '{16'd20000, 16'd32441, 16'd12345, 16'd54321, 16'hFFFE, 63, 35},
        '{16'd3277, 16'd16384, 16'd6554, 16'd655, 16'd0,    0,  0},
        '{16'd8000, 16'd32768, 16'd40000, 16'd20000, 16'd1, 0,  0}
    };

    // Clock generation.
    always #(CLK_PERIOD / 2) clk = ~clk;

    // Predicts the result of one frame and advances the gain state.
    function automatic res_t predict_gain_result(input sample_t left, input sample_t right,
                                                 input logic last);
        res_t    outcome;
        int      lmag;
        int      rmag;
        int      thr_eff;
        int      depth_eff;
        int      target;
        longint  coeff;
        longint  step;
        longint  next_gain;

        lmag = (left < 0) ? -int'(left) : int'(left);
        rmag = (right < 0) ? -int'(right) : int'(right);
        if (reg_model.mono_mic)
            rmag = lmag;
        if (lmag > peak_track)
            peak_track = lmag;
        if (rmag > peak_track)
            peak_track = rmag;
        outcome = '0;
        outcome.peak_ready = last;

        // Block end: pick the target, take one rounded step toward it and clamp.
        if (last)
        begin
            outcome.block_peak = peak_track[15:0];
            thr_eff = (reg_model.threshold == 0) ? 1 : int'(reg_model.threshold);
            depth_eff = (reg_model.depth > UNITY_GAIN) ? int'(UNITY_GAIN) : int'(reg_model.depth);
            target = (peak_track >= thr_eff) ? depth_eff : int'(UNITY_GAIN);
            duck_track = (target <= int'(DUCK_LIMIT));
            coeff = (target < gain_track) ? longint'(reg_model.attack_coeff)
                                          : longint'(reg_model.release_coeff);
            step = ((longint'(target) - longint'(gain_track)) * coeff + 64'sd32768) >>> 16;
            next_gain = longint'(gain_track) + step;
            if (next_gain < depth_eff)
                next_gain = depth_eff;
            if (next_gain > int'(UNITY_GAIN))
                next_gain = UNITY_GAIN;
            gain_track = int'(next_gain);
            peak_track = 0;
        end
        outcome.smooth_gain = gain_track[15:0];
        outcome.ducking_on = duck_track;
        return outcome;
    endfunction

    // Picks a sample: quiet blocks stay below the threshold, loud ones reach extremes.
    function automatic sample_t pick_sample(input bit loud);
        int thr_eff;
        int level;

        thr_eff = (reg_model.threshold == 0) ? 1 : int'(reg_model.threshold);
        if (!loud)
            level = $urandom_range(0, thr_eff - 1);
        else
        begin
            case ($urandom_range(0, 5))
                0: return 16'sh8000;
                1: return 16'sh7FFF;
                2, 3: level = $urandom_range((thr_eff > 32) ? thr_eff - 32 : 0,
                                             (thr_eff + 32 > 32767) ? 32767 : thr_eff + 32);
                default: return sample_t'($urandom);
            endcase
        end
        return $urandom_range(0, 1) ? sample_t'(-level) : sample_t'(level);
    endfunction

    // Writes one register and mirrors it in the predictor; unused indexes change nothing.
    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [CFG_DATA_WIDTH-1:0] data);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        case (idx)
            CFG_THRESHOLD: reg_model.threshold     = data[14:0];
            CFG_DEPTH:     reg_model.depth         = data;
            CFG_ATTACK:    reg_model.attack_coeff  = data;
            CFG_RELEASE:   reg_model.release_coeff = data;
            CFG_MONO:      reg_model.mono_mic      = data[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Sends one frame, idling at random first, and queues its expected result.
    task automatic send_frame(input sample_t left, input sample_t right, input logic last,
                              input bit fixed, input res_t fixed_want);
        res_t want;

        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle)
        begin
            frame_if.valid <= 1'b0;
            @(negedge clk);
        end
        frame_if.valid     <= 1'b1;
        frame_if.mic_left  <= left;
        frame_if.mic_right <= right;
        frame_if.block_end <= last;
        @(posedge clk);
        while (frame_if.ready !== 1'b1)
            @(posedge clk);
        want = predict_gain_result(left, right, last);
        if (fixed)
            want = fixed_want;
        gain_expect_q.push_back(want);
        frames_sent++;
    endtask

    // Holds the sender idle until every expected result has come back.
    task automatic drain_results();
        @(negedge clk);
        frame_if.valid <= 1'b0;
        while (gain_expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Random traffic: mostly whole blocks with random content, some loose frames.
    task automatic run_random_items(input int item_goal);
        int sent;
        int blk_len;
        bit loud;

        sent = 0;
        while (sent < item_goal)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_frame(sample_t'($urandom), sample_t'($urandom), 1'($urandom_range(0, 1)),
                           1'b0, '0);
                sent++;
            end
            else
            begin
                blk_len = $urandom_range(1, 8);
                loud = ($urandom_range(0, 99) < 40);
                for (int k = 0; k < blk_len; k++)
                begin
                    send_frame(pick_sample(loud), pick_sample(loud), k == blk_len - 1,
                               1'b0, '0);
                    sent++;
                end
            end
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            err_count++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Result side: random stalls at the current rate.
    initial
    begin
        result_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            result_if.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Compares each result transaction with the oldest expectation.
    always @(posedge clk)
    begin : result_monitor
        res_t want;
        if (result_if.valid === 1'b1 && result_if.ready === 1'b1)
        begin
            if (gain_expect_q.size() == 0)
            begin
                err_count++;
                $display("%0t ns: unexpected result, expected none, actual gain %0d peak %0d",
                         $time, result_if.smooth_gain, result_if.block_peak);
            end
            else
            begin
                want = gain_expect_q.pop_front();
                check_field("smooth_gain", want.smooth_gain, result_if.smooth_gain);
                check_field("ducking_on", want.ducking_on, result_if.ducking_on);
                check_field("block_peak", want.block_peak, result_if.block_peak);
                check_field("peak_ready", want.peak_ready, result_if.peak_ready);
            end
            if (result_if.peak_ready === 1'b1)
            begin
                blocks_seen++;
                if (result_if.ducking_on === 1'b1)
                    ducked_seen++;
            end
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge clk)
    begin
        if ((frame_if.valid === 1'b1 && frame_if.ready === 1'b1) ||
            (result_if.valid === 1'b1 && result_if.ready === 1'b1))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t ns: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Main sequence: reset, directed table, then the random phases.
    initial
    begin
        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_index          = '0;
        cfg_wdata          = '0;
        frame_if.valid     = 1'b0;
        frame_if.mic_left  = '0;
        frame_if.mic_right = '0;
        frame_if.block_end = 1'b0;

        reg_model.threshold     = THRESHOLD_RESET;
        reg_model.depth         = DEPTH_RESET;
        reg_model.attack_coeff  = ATTACK_RESET;
        reg_model.release_coeff = RELEASE_RESET;
        reg_model.mono_mic      = 1'b0;
        peak_track = 0;
        gain_track = UNITY_GAIN;
        duck_track = 1'b0;

        send_idle = phase_setups[0].send_idle;
        stall_pct = phase_setups[0].recv_idle;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < NUM_DIRECTED; i++)
            send_frame(directed_rows[i].left, directed_rows[i].right, directed_rows[i].last,
                       directed_rows[i].fixed, directed_rows[i].want);
        drain_results();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_reg(CFG_THRESHOLD, phase_setups[p].thr_word);
            write_reg(CFG_DEPTH, phase_setups[p].depth_word);
            write_reg(CFG_ATTACK, phase_setups[p].attack_word);
            write_reg(CFG_RELEASE, phase_setups[p].release_word);
            write_reg(CFG_MONO, phase_setups[p].mono_word);
            // Writes to indexes past the last register must leave the settings alone.
            if (p == 1)
                for (int idx = CFG_MONO + 1; idx < 2 ** CFG_INDEX_WIDTH; idx++)
                    write_reg(CFG_INDEX_WIDTH'(idx), CFG_DATA_WIDTH'($urandom));
            send_idle = phase_setups[p].send_idle;
            stall_pct = phase_setups[p].recv_idle;
            if (p == 0)
            begin
                // Pause the sender mid-phase until the pipeline is empty.
                run_random_items(PHASE_ITEMS / 2);
                drain_results();
                run_random_items(PHASE_ITEMS / 2);
            end
            else
                run_random_items(PHASE_ITEMS);
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (gain_expect_q.size() != 0)
        begin
            err_count++;
            $display("%0t ns: results missing, expected %0d more, actual 0",
                     $time, gain_expect_q.size());
        end

        $display("Sent %0d frames over %0d register settings; %0d blocks ended, %0d ducked.",
                 frames_sent, NUM_PHASES + 1, blocks_seen, ducked_seen);
        $display("Mismatches found: %0d.", err_count);
        if (err_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[filelist.f]
hdl/dgs_pkg.sv
hdl/dgs_in_if.sv
hdl/dgs_out_if.sv
hdl/dgs_cfg_regs.sv
hdl/dgs_core.sv
hdl/ducking_gain_smoother.sv
tb/sv/ducking_gain_smoother_tb.sv
